FILE: hw/rtl/clm_pkg.sv
// Shared types and constants of the clipped moving-average RMS level monitor.
`default_nettype none

package clm_pkg;

   // Fixed widths of the datapath
   localparam int WIN_W      = 3;   // window length register
   localparam int HIST_W     = 16;  // clipped samples and averages
   localparam int SUM_W      = 19;  // signed sum of up to seven clipped samples
   localparam int MAG_W      = 18;  // magnitude of the sum plus half the window
   localparam int QUO_W      = 33;  // sum of up to seven squared averages
   localparam int STEP_W     = 6;   // iteration counters of the divider and root units
   localparam int ROOT_W     = 17;  // integer square root of a QUO_W value
   localparam int RAD_REM_W  = 19;  // partial remainder of the root unit
   localparam int GPROD_W    = 34;  // root times gain
   localparam int LEVEL_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LIMIT = 2'd3;

   // Register reset values
   localparam logic [WIN_W-1:0]          WINDOW_LEN_RESET  = 3'd4;
   localparam logic signed [GAIN_W-1:0]  GAIN_RESET        = 16'sd10240;
   localparam logic [LIMIT_W-1:0]        CLIP_LIMIT_RESET  = 15'd6144;
   localparam logic [LIMIT_W-1:0]        ALARM_LIMIT_RESET = 15'd12288;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_NOMINAL   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERLOAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERLOAD = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;      // latch the request, clear histories on frame start
      logic             clip;      // clip the sample, seed the sum
      logic             sum_add;   // add clipped history entry idx
      logic             mag;       // magnitude of the sum plus rounding offset
      logic             div_avg;   // start the divider on the average
      logic             avg;       // take the signed average, clear the accumulator
      logic             sq_mul;    // square average entry idx
      logic             sq_acc;    // accumulate the previous square
      logic             div_ms;    // start the divider on the mean square
      logic             sqrt_go;   // start the root unit
      logic             gain_mul;  // multiply root by gain
      logic             finish;    // load the result register, push histories
      logic [WIN_W-1:0] idx;
   } clm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [WIN_W-1:0] win;        // effective window length, 1..7, capped at MAX_WINDOW of the datapath
      logic             div_done;
      logic             sqrt_done;
   } clm_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/clm_div.sv
// Restoring divider by a small divisor, one quotient bit per cycle.
`default_nettype none

module clm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [clm_pkg::QUO_W-1:0]     dividend,
   input  logic [clm_pkg::WIN_W-1:0]     divisor,
   input  logic [clm_pkg::STEP_W-1:0]    steps,
   output logic [clm_pkg::QUO_W-1:0]     quotient,
   output logic                          done
);
   import clm_pkg::*;

   logic [QUO_W-1:0]  quo_ff;
   logic [WIN_W-1:0]  rem_ff;
   logic [WIN_W-1:0]  div_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;

   logic [WIN_W:0]    rem_sh;
   logic [WIN_W:0]    rem_diff;
   logic              fits;
   logic [WIN_W-1:0]  rem_in;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[QUO_W-1]};
      fits     = (rem_sh >= {1'b0, div_ff});
      rem_diff = rem_sh - {1'b0, div_ff};
      rem_in   = fits ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend;
            rem_ff <= '0;
            div_ff <= divisor;
            cnt_ff <= steps;
         end else if (cnt_ff != '0) begin
            quo_ff  <= {quo_ff[QUO_W-2:0], fits};
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff - STEP_W'(1);
            done_ff <= (cnt_ff == STEP_W'(1));
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/clm_sqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none

module clm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [clm_pkg::QUO_W-1:0]     radicand,
   output logic [clm_pkg::ROOT_W-1:0]    root,
   output logic                          done
);
   import clm_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int SH_W  = RAD_REM_W + 2;

   logic [RAD_W-1:0]     x_ff;
   logic [RAD_REM_W-1:0] rem_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic                 done_ff;

   logic [SH_W-1:0]      rem_sh;
   logic [SH_W-1:0]      trial;
   logic [SH_W-1:0]      rem_diff;
   logic                 fits;

   always_comb begin
      rem_sh   = {rem_ff, x_ff[RAD_W-1 -: 2]};
      trial    = SH_W'({root_ff, 2'b01});
      fits     = (rem_sh >= trial);
      rem_diff = rem_sh - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= RAD_W'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= STEP_W'(ROOT_W);
         end else if (cnt_ff != '0) begin
            x_ff    <= {x_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= fits ? rem_diff[RAD_REM_W-1:0] : rem_sh[RAD_REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], fits};
            cnt_ff  <= cnt_ff - STEP_W'(1);
            done_ff <= (cnt_ff == STEP_W'(1));
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/clm_dp.sv
// Datapath: registers, histories, clip, sum, squares, gain and result register.
`default_nettype none

module clm_dp #(
   parameter int MAX_WINDOW  = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clm_pkg::clm_cmd_type                 cmd,
   output clm_pkg::clm_stat_type                stat,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic                                 req_frame_start,
   output logic signed [clm_pkg::LEVEL_W-1:0]   rsp_level,
   output logic [clm_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_write,
   input  logic [clm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [clm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import clm_pkg::*;

   localparam int HD    = MAX_WINDOW - 1;
   localparam int NCAP  = (MAX_WINDOW < 7) ? MAX_WINDOW : 7;
   localparam int CMP_W = ((SAMPLE_BITS > HIST_W) ? SAMPLE_BITS : HIST_W) + 1;
   localparam int RND_W = GPROD_W + 1;
   localparam int LVL_W = RND_W - 12;

   // Configuration
   logic [WIN_W-1:0]         window_len_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [LIMIT_W-1:0]       clip_limit_ff;
   logic [LIMIT_W-1:0]       alarm_limit_ff;

   // Histories, most recent first
   logic signed [HIST_W-1:0] chist_ff [HD];
   logic signed [HIST_W-1:0] ahist_ff [HD];

   // Working registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [HIST_W-1:0]      clipped_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic [MAG_W-1:0]              magp_ff;
   logic                          sum_neg_ff;
   logic signed [HIST_W-1:0]      avg_ff;
   logic [2*HIST_W-1:0]           sq_ff;
   logic [QUO_W-1:0]              acc_ff;
   logic signed [GPROD_W-1:0]     gprod_ff;
   logic signed [LEVEL_W-1:0]     level_ff;
   logic [STATUS_W-1:0]           status_ff;

   logic [WIN_W-1:0]              win;
   logic signed [CMP_W-1:0]       s_ext;
   logic signed [CMP_W-1:0]       clip_pos;
   logic signed [HIST_W-1:0]      clipped_in;
   logic signed [HIST_W-1:0]      csel;
   logic signed [HIST_W-1:0]      asel;
   logic signed [HIST_W-1:0]      sq_op;
   logic signed [2*HIST_W-1:0]    sq_full;
   logic signed [SUM_W-1:0]       sum_abs;
   logic [QUO_W-1:0]              div_dividend;
   logic [STEP_W-1:0]             div_steps;
   logic [QUO_W-1:0]              quotient;
   logic                          div_done;
   logic [ROOT_W-1:0]             root;
   logic                          sqrt_done;
   logic signed [HIST_W-1:0]      quo_avg;
   logic signed [RND_W-1:0]       rnd;
   logic signed [LVL_W-1:0]       lvl_wide;
   logic signed [LEVEL_W-1:0]     level_in;
   logic signed [LEVEL_W:0]       lvl_cmp;
   logic signed [LEVEL_W:0]       alarm_pos;
   logic [STATUS_W-1:0]           status_in;

   // Effective window length
   always_comb begin
      priority if (window_len_ff == '0) begin
         win = WIN_W'(1);
      end else if (window_len_ff > WIN_W'(NCAP)) begin
         win = WIN_W'(NCAP);
      end else begin
         win = window_len_ff;
      end
   end

   // Clip to plus or minus the limit
   always_comb begin
      s_ext    = CMP_W'(sample_ff);
      clip_pos = signed'(CMP_W'(clip_limit_ff));
      priority if (s_ext > clip_pos) begin
         clipped_in = HIST_W'(clip_pos);
      end else if (s_ext < -clip_pos) begin
         clipped_in = HIST_W'(-clip_pos);
      end else begin
         clipped_in = HIST_W'(s_ext);
      end
   end

   // History taps selected by the controller's index
   always_comb begin
      csel = '0;
      asel = '0;
      for (int i = 0; i < HD; i++) begin
         if (int'(cmd.idx) == i) begin
            csel = chist_ff[i];
         end
         if (int'(cmd.idx) == i + 1) begin
            asel = ahist_ff[i];
         end
      end
      sq_op   = (cmd.idx == '0) ? avg_ff : asel;
      // full-width square
      sq_full = (2*HIST_W)'(sq_op) * (2*HIST_W)'(sq_op);
   end

   always_comb begin
      sum_abs = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      quo_avg = signed'(quotient[HIST_W-1:0]);
   end

   // Shared divider: left-align the short dividend and run fewer steps
   always_comb begin
      if (cmd.div_avg) begin
         div_dividend = {magp_ff, {(QUO_W - MAG_W){1'b0}}};
         div_steps    = STEP_W'(MAG_W);
      end else begin
         div_dividend = acc_ff;
         div_steps    = STEP_W'(QUO_W);
      end
   end

   clm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_avg | cmd.div_ms),
      .dividend (div_dividend),
      .divisor  (win),
      .steps    (div_steps),
      .quotient (quotient),
      .done     (div_done)
   );

   clm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_go),
      .radicand (quotient),
      .root     (root),
      .done     (sqrt_done)
   );

   // Round half up, saturate, classify
   always_comb begin
      rnd      = RND_W'(gprod_ff) + RND_W'(2048);
      lvl_wide = rnd[RND_W-1:12];
      priority if (lvl_wide > LVL_W'(32767)) begin
         level_in = 16'sh7FFF;
      end else if (lvl_wide < -LVL_W'(32768)) begin
         level_in = 16'sh8000;
      end else begin
         level_in = lvl_wide[LEVEL_W-1:0];
      end
      lvl_cmp   = (LEVEL_W + 1)'(level_in);
      alarm_pos = signed'((LEVEL_W + 1)'(alarm_limit_ff));
      priority if (lvl_cmp > alarm_pos) begin
         status_in = STATUS_OVERLOAD;
      end else if (lvl_cmp < -alarm_pos) begin
         status_in = STATUS_UNDERLOAD;
      end else begin
         status_in = STATUS_NOMINAL;
      end
   end

   // Configuration and histories
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= WINDOW_LEN_RESET;
         gain_ff        <= GAIN_RESET;
         clip_limit_ff  <= CLIP_LIMIT_RESET;
         alarm_limit_ff <= ALARM_LIMIT_RESET;
         for (int i = 0; i < HD; i++) begin
            chist_ff[i] <= '0;
            ahist_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_WINDOW_LEN:  window_len_ff  <= csr_data[WIN_W-1:0];
               CSR_GAIN:        gain_ff        <= signed'(csr_data[GAIN_W-1:0]);
               CSR_CLIP_LIMIT:  clip_limit_ff  <= csr_data[LIMIT_W-1:0];
               CSR_ALARM_LIMIT: alarm_limit_ff <= csr_data[LIMIT_W-1:0];
            endcase
         end
         if (cmd.load && req_frame_start) begin
            for (int i = 0; i < HD; i++) begin
               chist_ff[i] <= '0;
               ahist_ff[i] <= '0;
            end
         end else if (cmd.finish && HD > 0) begin
            chist_ff[0] <= clipped_ff;
            ahist_ff[0] <= avg_ff;
            for (int i = 1; i < HD; i++) begin
               chist_ff[i] <= chist_ff[i-1];
               ahist_ff[i] <= ahist_ff[i-1];
            end
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
      if (cmd.clip) begin
         clipped_ff <= clipped_in;
         sum_ff     <= SUM_W'(clipped_in);
      end
      if (cmd.sum_add) begin
         sum_ff <= sum_ff + SUM_W'(csel);
      end
      if (cmd.mag) begin
         magp_ff    <= sum_abs[MAG_W-1:0] + MAG_W'(win >> 1);
         sum_neg_ff <= sum_ff[SUM_W-1];
      end
      if (cmd.avg) begin
         avg_ff <= sum_neg_ff ? -quo_avg : quo_avg;
         acc_ff <= '0;
      end
      if (cmd.sq_mul) begin
         sq_ff <= unsigned'(sq_full);
      end
      if (cmd.sq_acc) begin
         acc_ff <= acc_ff + QUO_W'(sq_ff);
      end
      if (cmd.gain_mul) begin
         gprod_ff <= signed'({1'b0, root}) * gain_ff;
      end
      if (cmd.finish) begin
         level_ff  <= level_in;
         status_ff <= status_in;
      end
   end

   assign stat.win       = win;
   assign stat.div_done  = div_done;
   assign stat.sqrt_done = sqrt_done;
   assign rsp_level      = level_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/clm_ctrl.sv
// Controller: sequences one request through the datapath and owns the handshakes.
`default_nettype none

module clm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  clm_pkg::clm_stat_type  stat,
   output clm_pkg::clm_cmd_type   cmd
);
   import clm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLIP,
      S_SUM,
      S_MAG,
      S_DIVA_GO,
      S_DIVA_WAIT,
      S_AVG,
      S_SQ,
      S_DIVM_GO,
      S_DIVM_WAIT,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_MUL,
      S_FIN
   } state_type;

   state_type        state_ff;
   logic [WIN_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd     = '0;
      cmd.idx = cnt_ff;
      unique case (state_ff)
         S_IDLE:      cmd.load     = req_valid;
         S_CLIP:      cmd.clip     = 1'b1;
         S_SUM:       cmd.sum_add  = 1'b1;
         S_MAG:       cmd.mag      = 1'b1;
         S_DIVA_GO:   cmd.div_avg  = 1'b1;
         S_DIVA_WAIT: cmd.idx      = cnt_ff;
         S_AVG:       cmd.avg      = 1'b1;
         S_SQ: begin
            cmd.sq_mul = (cnt_ff < stat.win);
            cmd.sq_acc = (cnt_ff != '0);
         end
         S_DIVM_GO:   cmd.div_ms   = 1'b1;
         S_DIVM_WAIT: cmd.idx      = cnt_ff;
         S_SQRT_GO:   cmd.sqrt_go  = 1'b1;
         S_SQRT_WAIT: cmd.idx      = cnt_ff;
         S_MUL:       cmd.gain_mul = 1'b1;
         S_FIN:       cmd.finish   = out_free;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CLIP;
               end
            end
            S_CLIP: begin
               cnt_ff   <= '0;
               state_ff <= (stat.win > WIN_W'(1)) ? S_SUM : S_MAG;
            end
            S_SUM: begin
               if (cnt_ff == stat.win - WIN_W'(2)) begin
                  state_ff <= S_MAG;
               end else begin
                  cnt_ff <= cnt_ff + WIN_W'(1);
               end
            end
            S_MAG:     state_ff <= S_DIVA_GO;
            S_DIVA_GO: state_ff <= S_DIVA_WAIT;
            S_DIVA_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_AVG;
               end
            end
            S_AVG: begin
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               // one extra pass to accumulate the last square
               if (cnt_ff == stat.win) begin
                  state_ff <= S_DIVM_GO;
               end else begin
                  cnt_ff <= cnt_ff + WIN_W'(1);
               end
            end
            S_DIVM_GO: state_ff <= S_DIVM_WAIT;
            S_DIVM_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= S_SQRT_GO;
               end
            end
            S_SQRT_GO: state_ff <= S_SQRT_WAIT;
            S_SQRT_WAIT: begin
               if (stat.sqrt_done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: state_ff <= S_FIN;
            S_FIN: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/clip_sma_rms_level_monitor_top.sv
// Top level of the clipped moving-average RMS level monitor.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_sample, req_frame_start
//   rsp      out        rsp_valid / rsp_stall   rsp_level, rsp_status
//   csr      in         csr_write               csr_index, csr_data
//
// The time from one acceptance to the next grows with n, the effective window length;
// the shared one-bit-per-cycle divider (used for the average and the mean square) and
// the one-bit-per-cycle square root set most of it.
// Reset is synchronous and restores the register defaults and zeroed histories.
// A finished result waits in the output register while the next request is accepted;
// a further result holds in the last step until that register is free.
`default_nettype none

module clip_sma_rms_level_monitor_top #(
   parameter int MAX_WINDOW  = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [clm_pkg::LEVEL_W-1:0]   rsp_level,
   output logic [clm_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_write,
   input  logic [clm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [clm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import clm_pkg::*;

   clm_cmd_type  cmd;
   clm_stat_type stat;

   clm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   clm_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .rsp_level       (rsp_level),
      .rsp_status      (rsp_status),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench of the clipped moving-average RMS level monitor: predicted levels checked per request.
`timescale 1ns / 1ps

module testbench;
   import clm_pkg::*;

   localparam int     MAX_WINDOW  = 4;
   localparam int     SAMPLE_BITS = 16;
   localparam int     HIST_DEPTH  = MAX_WINDOW - 1;
   localparam int     PHASES      = 8;
   localparam int     PHASE_ITEMS = 75;
   localparam longint CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic signed [LEVEL_W-1:0] level;
      logic [STATUS_W-1:0]       status;
   } level_result_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample      = '0;
   logic                          req_frame_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic signed [LEVEL_W-1:0]     rsp_level;
   logic [STATUS_W-1:0]           rsp_status;
   logic                          csr_write       = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index       = '0;
   logic [CSR_DATA_W-1:0]         csr_data        = '0;

   // Predictor copy of the registers and the two histories
   logic [WIN_W-1:0]          cfg_window = WINDOW_LEN_RESET;
   logic signed [GAIN_W-1:0]  cfg_gain   = GAIN_RESET;
   logic [LIMIT_W-1:0]        cfg_clip   = CLIP_LIMIT_RESET;
   logic [LIMIT_W-1:0]        cfg_alarm  = ALARM_LIMIT_RESET;
   longint                    clip_hist [HIST_DEPTH];
   longint                    avg_hist  [HIST_DEPTH];

   level_result_type expected_levels [$];
   level_result_type head_level;

   int     errors        = 0;
   int     sent_count    = 0;
   int     checked_count = 0;
   int     frame_count   = 0;
   int     setting_count = 0;
   int     status_tally [3] = '{0, 0, 0};
   longint cycle_count   = 0;
   int     stall_left    = 0;
   int     stall_len;
   bit     req_gaps_on   = 1'b1;
   bit     rsp_stalls_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   clip_sma_rms_level_monitor_top #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_status      (rsp_status),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         clip_hist[i] = 0;
         avg_hist[i]  = 0;
      end
   end

   // Mostly zero, sometimes a few cycles, rarely a long stretch
   function automatic int pick_idle(input bit enabled, input int quiet_permille,
                                    input int long_permille, input int long_max);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 999);
      if (r < quiet_permille) return 0;
      if (r >= 1000 - long_permille) return $urandom_range(10, long_max);
      return $urandom_range(1, 3);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned root;
      longint unsigned step_bit;
      root     = 0;
      step_bit = 64'h1 << 62;
      while (step_bit > x) step_bit >>= 2;
      while (step_bit != 0) begin
         if (x >= root + step_bit) begin
            x    -= root + step_bit;
            root  = (root >> 1) + step_bit;
         end else begin
            root >>= 1;
         end
         step_bit >>= 2;
      end
      return root;
   endfunction

   task automatic predict_level(input logic signed [SAMPLE_BITS-1:0] sample,
                                input logic frame_start);
      int               n;
      longint           lim;
      longint           alarm;
      longint           c;
      longint           sum;
      longint           mag;
      longint           avg;
      longint           lvl;
      longint unsigned  sq;
      longint unsigned  r;
      level_result_type res;
      n = (cfg_window == 0) ? 1 : (cfg_window > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window);
      lim   = cfg_clip;
      alarm = cfg_alarm;
      if (frame_start) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            clip_hist[i] = 0;
            avg_hist[i]  = 0;
         end
      end
      c = sample;
      if (c > lim) c = lim;
      else if (c < -lim) c = -lim;
      sum = c;
      for (int i = 0; i + 1 < n; i++) sum += clip_hist[i];
      // round to nearest, ties away from zero
      mag = (sum < 0) ? -sum : sum;
      avg = (mag + n / 2) / n;
      if (sum < 0) avg = -avg;
      sq = avg * avg;
      for (int i = 0; i + 1 < n; i++) sq += avg_hist[i] * avg_hist[i];
      r = floor_sqrt(sq / n);
      lvl = (longint'(r) * longint'(cfg_gain) + 2048) >>> 12;
      if (lvl > 32767) lvl = 32767;
      else if (lvl < -32768) lvl = -32768;
      res.level = lvl[LEVEL_W-1:0];
      if (lvl > alarm) res.status = STATUS_OVERLOAD;
      else if (lvl < -alarm) res.status = STATUS_UNDERLOAD;
      else res.status = STATUS_NOMINAL;
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         clip_hist[i] = clip_hist[i-1];
         avg_hist[i]  = avg_hist[i-1];
      end
      clip_hist[0] = c;
      avg_hist[0]  = avg;
      expected_levels.push_back(res);
   endtask

   // Leaves req_valid high; the next request or a drain decides what follows
   task automatic send_request(input logic signed [SAMPLE_BITS-1:0] sample,
                               input logic frame_start);
      int gap;
      gap = pick_idle(req_gaps_on, 500, 80, 150);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_frame_start <= frame_start;
      do @(posedge clock); while (req_stall);
      predict_level(sample, frame_start);
      sent_count++;
      if (frame_start) frame_count++;
   endtask

   task automatic drain_levels;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_levels.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_WINDOW_LEN:  cfg_window = data[WIN_W-1:0];
         CSR_GAIN:        cfg_gain   = data;
         CSR_CLIP_LIMIT:  cfg_clip   = data[LIMIT_W-1:0];
         CSR_ALARM_LIMIT: cfg_alarm  = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Unused upper bits of the write data get random values
   task automatic configure(input int window, input int gain, input int clip, input int alarm);
      logic [CSR_DATA_W-WIN_W-1:0] pad;
      pad = $urandom;
      write_reg(CSR_WINDOW_LEN, {pad, WIN_W'(window)});
      write_reg(CSR_GAIN, CSR_DATA_W'(gain));
      write_reg(CSR_CLIP_LIMIT, {1'($urandom), LIMIT_W'(clip)});
      write_reg(CSR_ALARM_LIMIT, {1'($urandom), LIMIT_W'(alarm)});
      csr_write <= 1'b0;
      setting_count++;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom_range(0, 65535) - 32768;
         2: v = (int'(cfg_clip) + $urandom_range(0, 8) - 4) * ($urandom_range(0, 1) ? 1 : -1);
         3: v = $urandom_range(0, 128) - 64;
         4: v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = $urandom_range(0, 2 * int'(cfg_clip)) - int'(cfg_clip);
      endcase
      return SAMPLE_BITS'(v);
   endfunction

   task automatic test_default_config;
      send_request(16'sd32767, 1'b1);
      send_request(-16'sd32768, 1'b0);
      send_request(16'sd0, 1'b0);
      send_request(16'sd6145, 1'b0);
      send_request(-16'sd1, 1'b1);
   endtask

   // Zero and oversized lengths clamp to one and to the maximum
   task automatic test_window_extremes;
      drain_levels();
      configure(0, 32767, 32767, 0);
      send_request(16'sd32767, 1'b1);
      send_request(-16'sd32768, 1'b0);
      drain_levels();
      configure(7, 4096, 32767, 32767);
      send_request(-16'sd32768, 1'b1);
      send_request(16'sd32767, 1'b0);
      send_request(16'sd100, 1'b0);
      send_request(-16'sd100, 1'b0);
      drain_levels();
      configure(1, 12345, 4096, 2000);
      send_request(16'sd20000, 1'b0);
      send_request(-16'sd5000, 1'b0);
   endtask

   task automatic test_negative_gain;
      drain_levels();
      configure(2, -32768, 32767, 1000);
      send_request(16'sd32767, 1'b1);
      send_request(-16'sd32768, 1'b0);
      send_request(16'sd0, 1'b0);
      drain_levels();
      configure(3, 0, 32767, 0);
      send_request(16'sd1, 1'b0);
   endtask

   task automatic test_zero_limits;
      drain_levels();
      configure(MAX_WINDOW, 32767, 0, 0);
      send_request(16'sd32767, 1'b1);
      send_request(-16'sd32768, 1'b0);
   endtask

   // Frames of random length, with some stray frame starts and mid-frame drains
   task automatic test_random_frames;
      int   gain;
      int   frame_left;
      logic fs;
      for (int p = 0; p < PHASES; p++) begin
         drain_levels();
         gain = $urandom_range(0, 65535) - 32768;
         if ($urandom_range(0, 1)) gain = $urandom_range(0, 16384) - 4096;
         case (p)
            0: configure(MAX_WINDOW, 32767, 32767, 32767);
            1: configure(1, -32768, 32767, 0);
            default: configure($urandom_range(0, 7), gain,
                               $urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                    : $urandom_range(100, 8192),
                               $urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 16384));
         endcase
         req_gaps_on   = (p != 2);
         rsp_stalls_on = (p != 2);
         frame_left = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            fs = 1'b0;
            if (frame_left == 0) begin
               fs         = 1'b1;
               frame_left = $urandom_range(1, 12);
            end else if ($urandom_range(0, 19) == 0) begin
               fs = 1'b1;
            end
            frame_left--;
            send_request(random_sample(), fs);
            if ($urandom_range(0, 49) == 0) drain_levels();
         end
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_len  = pick_idle(rsp_stalls_on, 750, 3, 150);
         rsp_stall <= (stall_len != 0);
         stall_left = (stall_len > 0) ? stall_len - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $error("unexpected result: level %0d status %0d", rsp_level, rsp_status);
            errors++;
         end else begin
            head_level = expected_levels.pop_front();
            if (rsp_level !== head_level.level) begin
               $error("level: expected %0d, got %0d", head_level.level, rsp_level);
               errors++;
            end
            if (rsp_status !== head_level.status) begin
               $error("status: expected %0d, got %0d", head_level.status, rsp_status);
               errors++;
            end
            if (head_level.status < 3) status_tally[head_level.status]++;
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d levels outstanding",
                  cycle_count, expected_levels.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_window_extremes();
      test_negative_gain();
      test_zero_limits();
      test_random_frames();
      drain_levels();
      repeat (2 * MAX_WINDOW + 100) @(posedge clock);
      if (expected_levels.size() != 0) begin
         $error("%0d expected levels never arrived", expected_levels.size());
         errors++;
      end
      $display("Sent %0d samples in %0d frames under %0d register settings.",
               sent_count, frame_count, setting_count);
      $display("Checked %0d levels: %0d nominal, %0d overload, %0d underload.",
               checked_count, status_tally[STATUS_NOMINAL], status_tally[STATUS_OVERLOAD],
               status_tally[STATUS_UNDERLOAD]);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: clip_sma_rms_level_monitor_top.f
hw/rtl/clm_pkg.sv
hw/rtl/clm_div.sv
hw/rtl/clm_sqrt.sv
hw/rtl/clm_dp.sv
hw/rtl/clm_ctrl.sv
hw/rtl/clip_sma_rms_level_monitor_top.sv
tb/testbench.sv
